@@ rtl/interpolating_lookup_table_assert.svh @@
// assertion macros for the interpolating lookup table
`ifndef INTERPOLATING_LOOKUP_TABLE_ASSERT_SVH
`define INTERPOLATING_LOOKUP_TABLE_ASSERT_SVH

// same-cycle implication
`define ILT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ILT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ilt_pkg.sv @@
// constants, codes and address helper for the interpolating lookup table
package ilt_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int FRACTION_BITS = 6;
   localparam int TABLE_COUNT   = 4;

   localparam int VALUE_W  = 32;
   localparam int CTRL_W   = 16;
   localparam int ENTRY_W  = 10;
   localparam int SEL_W    = 2;

   localparam int STORE_DEPTH = TABLE_ENTRIES * TABLE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = $clog2(TABLE_ENTRIES);
   localparam int SEG_W       = CTRL_W - FRACTION_BITS;

   localparam int DIVISOR    = (1 << FRACTION_BITS) - 1;
   localparam int MAG_W      = VALUE_W + 1;
   localparam int GUARD_W    = 6;
   localparam int X_W        = MAG_W + GUARD_W;
   localparam int TERM_COUNT = (X_W + FRACTION_BITS) / FRACTION_BITS;
   localparam int HALF_TERMS = (TERM_COUNT + 1) / 2;
   localparam int SUM_W      = X_W + 1;
   localparam int REM_W      = MAG_W + FRACTION_BITS + 1;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   function automatic logic [ADDR_W-1:0] ilt_addr(input logic [SEL_W-1:0] sel,
                                                  input logic [IDX_W-1:0] idx);
      ilt_addr = ADDR_W'(int'(sel) * TABLE_ENTRIES + int'(idx));
   endfunction

endpackage

@@ rtl/ilt_ram.sv @@
// generic two-read one-write ram with registered read
module ilt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/interpolating_lookup_table.sv @@
// interpolating lookup table: breakpoint store and seven-stage lookup pipeline
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  action, table_sel, entry_index,
//                                            entry_value, control_in
//   rsp      out        rsp_valid/rsp_stall  result_value
//
// one request per cycle while req_stall is low; a lookup answers after passing stages 1 to 7
// the store ram (one write, two reads a cycle) bounds the rate at one request
// a load writes the ram at the cycle it is taken and gives no response
// reset clears only the stage valid bits; the store holds garbage until loaded
// a stall on rsp fills the empty stages first, then holds req_stall high
`include "interpolating_lookup_table_assert.svh"

module interpolating_lookup_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [ilt_pkg::SEL_W-1:0]           req_table_sel,
   input  logic [ilt_pkg::ENTRY_W-1:0]         req_entry_index,
   input  logic signed [ilt_pkg::VALUE_W-1:0]  req_entry_value,
   input  logic [ilt_pkg::CTRL_W-1:0]          req_control_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ilt_pkg::VALUE_W-1:0]  rsp_result_value
);

   import ilt_pkg::*;

   // stage enables
   logic en1, en2, en3, en4, en5, en6, en7;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic accept;

   // request decode
   logic [SEG_W-1:0]  seg_raw;
   logic              seg_last;
   logic [IDX_W-1:0]  lo_idx;
   logic [IDX_W-1:0]  hi_idx;
   logic              tbl_present;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] lo_addr;
   logic [ADDR_W-1:0] hi_addr;
   logic              v1_in;

   // stage 1
   logic                     zero1_ff, last1_ff;
   logic [FRACTION_BITS-1:0] frac1_ff;
   logic [VALUE_W-1:0]       lo_rd, hi_rd;

   // stage 2
   logic                     zero2_ff;
   logic [FRACTION_BITS-1:0] frac2_ff;
   logic [VALUE_W-1:0]       base2_ff;
   logic [MAG_W-1:0]         diff2_ff, diff2_in;

   // stage 3
   logic                     zero3_ff, neg3_ff;
   logic [FRACTION_BITS-1:0] frac3_ff;
   logic [VALUE_W-1:0]       base3_ff;
   logic [MAG_W-1:0]         mag3_ff, mag3_in;

   // stage 4
   logic                     zero4_ff, neg4_ff;
   logic [FRACTION_BITS-1:0] frac4_ff;
   logic [VALUE_W-1:0]       base4_ff;
   logic [MAG_W-1:0]         mag4_ff;
   logic [X_W-1:0]           x_val;
   logic [SUM_W-1:0]         pa4_ff, pa4_in, pb4_ff, pb4_in;

   // stage 5
   logic                     zero5_ff, neg5_ff;
   logic [FRACTION_BITS-1:0] frac5_ff;
   logic [VALUE_W-1:0]       base5_ff;
   logic [MAG_W-1:0]         mag5_ff;
   logic [SUM_W-1:0]         sum5;
   logic [MAG_W-1:0]         q5_ff, q5_in;

   // stage 6
   logic                     zero6_ff, neg6_ff;
   logic [FRACTION_BITS-1:0] frac6_ff;
   logic [VALUE_W-1:0]       base6_ff;
   logic [REM_W-1:0]         rem6;
   logic [MAG_W-1:0]         q6_ff, q6_in;

   // stage 7
   logic [VALUE_W+FRACTION_BITS-1:0] prod7;
   logic [VALUE_W-1:0]               res7_ff, res7_in;

   assign en7 = !v7_ff || !rsp_stall;
   assign en6 = !v6_ff || en7;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;
   assign accept    = req_valid && en1;

   assign seg_raw     = req_control_in[CTRL_W-1:FRACTION_BITS];
   assign seg_last    = int'(seg_raw) >= TABLE_ENTRIES - 1;
   assign lo_idx      = seg_last ? IDX_W'(TABLE_ENTRIES - 2) : IDX_W'(seg_raw);
   assign hi_idx      = seg_last ? IDX_W'(TABLE_ENTRIES - 1)
                                 : IDX_W'(seg_raw) + IDX_W'(1);
   assign tbl_present = int'(req_table_sel) < TABLE_COUNT;
   assign wr_en       = accept && (req_action == ACT_LOAD) && tbl_present
                        && (int'(req_entry_index) < TABLE_ENTRIES);
   assign wr_addr     = ilt_addr(req_table_sel, IDX_W'(req_entry_index));
   assign lo_addr     = ilt_addr(req_table_sel, lo_idx);
   assign hi_addr     = ilt_addr(req_table_sel, hi_idx);
   assign v1_in       = accept && (req_action == ACT_LOOKUP);

   ilt_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_entry_value),
      .rd_en     (en1),
      .rd_addr_a (lo_addr),
      .rd_addr_b (hi_addr),
      .rd_data_a (lo_rd),
      .rd_data_b (hi_rd)
   );

   // breakpoint difference, exact in 33 bits
   assign diff2_in = {hi_rd[VALUE_W-1], hi_rd} - {lo_rd[VALUE_W-1], lo_rd};
   assign mag3_in  = diff2_ff[MAG_W-1] ? (~diff2_ff + MAG_W'(1)) : diff2_ff;

   // divide by 2^f-1 as a geometric series of shifts
   assign x_val = {mag3_ff, GUARD_W'(0)};

   always_comb begin
      pa4_in = '0;
      pb4_in = '0;
      for (int i = 0; i < TERM_COUNT; i++) begin
         if (i < HALF_TERMS) begin
            pa4_in = pa4_in + SUM_W'(x_val >> (FRACTION_BITS * i));
         end else begin
            pb4_in = pb4_in + SUM_W'(x_val >> (FRACTION_BITS * i));
         end
      end
   end

   assign sum5  = pa4_ff + pb4_ff;
   assign q5_in = MAG_W'(sum5 >> (FRACTION_BITS + GUARD_W));

   // estimate is low by at most one
   assign rem6  = REM_W'(mag5_ff) - ((REM_W'(q5_ff) << FRACTION_BITS) - REM_W'(q5_ff));
   assign q6_in = (rem6 >= REM_W'(DIVISOR)) ? q5_ff + MAG_W'(1) : q5_ff;

   assign prod7   = frac6_ff * q6_ff[VALUE_W-1:0];
   assign res7_in = zero6_ff ? '0
                  : neg6_ff ? base6_ff - prod7[VALUE_W-1:0]
                  : base6_ff + prod7[VALUE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= v1_in;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         zero1_ff <= !tbl_present;
         last1_ff <= seg_last;
         frac1_ff <= req_control_in[FRACTION_BITS-1:0];
      end
      if (en2) begin
         zero2_ff <= zero1_ff;
         frac2_ff <= frac1_ff;
         base2_ff <= last1_ff ? hi_rd : lo_rd;
         diff2_ff <= diff2_in;
      end
      if (en3) begin
         zero3_ff <= zero2_ff;
         frac3_ff <= frac2_ff;
         base3_ff <= base2_ff;
         neg3_ff  <= diff2_ff[MAG_W-1];
         mag3_ff  <= mag3_in;
      end
      if (en4) begin
         zero4_ff <= zero3_ff;
         frac4_ff <= frac3_ff;
         base4_ff <= base3_ff;
         neg4_ff  <= neg3_ff;
         mag4_ff  <= mag3_ff;
         pa4_ff   <= pa4_in;
         pb4_ff   <= pb4_in;
      end
      if (en5) begin
         zero5_ff <= zero4_ff;
         frac5_ff <= frac4_ff;
         base5_ff <= base4_ff;
         neg5_ff  <= neg4_ff;
         mag5_ff  <= mag4_ff;
         q5_ff    <= q5_in;
      end
      if (en6) begin
         zero6_ff <= zero5_ff;
         frac6_ff <= frac5_ff;
         base6_ff <= base5_ff;
         neg6_ff  <= neg5_ff;
         q6_ff    <= q6_in;
      end
      if (en7) begin
         res7_ff <= res7_in;
      end
   end

   assign rsp_valid        = v7_ff;
   assign rsp_result_value = res7_ff;

   `ILT_ASSERT_NOW(a_stall_from_rsp, req_stall, rsp_valid && rsp_stall, "req stalled without rsp backpressure")
   `ILT_ASSERT_NEXT(a_load_no_rsp, accept && (req_action == ACT_LOAD), !v1_ff, "load entered the pipeline")
   `ILT_ASSERT_NEXT(a_lookup_enters, accept && (req_action == ACT_LOOKUP), v1_ff, "lookup lost at entry")
   `ILT_ASSERT_NOW(a_quot_close, v5_ff, rem6 < REM_W'(2 * DIVISOR), "quotient estimate off by more than one")

endmodule
